FILE: hw/rtl/f8vcw_pkg.sv
// f8vcw_pkg: shared types, codes, widths and the vote function of the
// allocation-table vote and chain-walk unit. No dependencies.
package f8vcw_pkg;

  // field and register widths fixed by the interface
  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 9;
  localparam int CS_W       = 5;
  localparam int CPT_W      = 7;
  localparam int SB_W       = 11;
  localparam int SECS_W     = 13;
  localparam int BYTES_W    = 23;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // defaults for the top-level parameters
  localparam int DEF_MAX_CLUSTERS = 256;
  localparam int DEF_COPIES       = 3;

  // table codes and limits
  localparam logic [BYTE_W-1:0]  END_BASE = 8'hC0;
  localparam logic [BYTES_W-1:0] BYTE_MAX = 23'h7F_FFFF;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_NUM_CLUSTERS  = 9'd160;
  localparam logic [CS_W-1:0]   RST_CLUSTER_SECS  = 5'd4;
  localparam logic [CPT_W-1:0]  RST_CLUSTERS_TRK  = 7'd4;
  localparam logic [SB_W-1:0]   RST_SECTOR_BYTES  = 11'd256;
  localparam logic [BYTE_W-1:0] RST_FREE_CODE     = 8'd255;
  localparam logic [BYTE_W-1:0] RST_RESERVED_CODE = 8'd254;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLUSTERS       = 3'd0,
    CFG_CLUSTER_SECTORS    = 3'd1,
    CFG_CLUSTERS_PER_TRACK = 3'd2,
    CFG_SECTOR_BYTES       = 3'd3,
    CFG_FREE_CODE          = 3'd4,
    CFG_RESERVED_CODE      = 3'd5
  } cfg_idx_t;

  // item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WALK  = 2'd2
  } op_t;

  // walk status codes
  typedef enum logic [STAT_W-1:0] {
    WS_OK        = 3'd0,
    WS_START_OUT = 3'd1,
    WS_CYCLIC    = 3'd2,
    WS_ILLEGAL   = 3'd3,
    WS_FREE      = 3'd4,
    WS_RESERVED  = 3'd5
  } walk_stat_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_WALK_INIT,
    S_WALK,
    S_MUL1,
    S_MUL2,
    S_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_en;
    logic scan_en;
    logic walk_init;
    logic walk_en;
    logic mul1_en;
    logic mul2_en;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic walk_op;
    logic start_out;
    logic walk_done;
    logic walk_ok;
  } dp_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              disagree;
  } vote_t;

  // majority of up to three copies; smallest value wins with no majority
  function automatic vote_t vote3(input int copies, input logic [BYTE_W-1:0] a,
                                  input logic [BYTE_W-1:0] b,
                                  input logic [BYTE_W-1:0] c);
    vote_t             r;
    logic [BYTE_W-1:0] mab;
    mab = (b < a) ? b : a;
    if (copies <= 1) begin
      r.value    = a;
      r.disagree = 1'b0;
    end else if (copies == 2) begin
      r.value    = mab;
      r.disagree = (a != b);
    end else begin
      if (a == b || a == c) begin
        r.value = a;
      end else if (b == c) begin
        r.value = b;
      end else begin
        r.value = (c < mab) ? c : mab;
      end
      r.disagree = !(a == b && a == c);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/f8vcw_ctrl.sv
// f8vcw_ctrl: sequencing state machine of the vote and chain-walk unit.
// Depends on f8vcw_pkg; drives the datapath through dp_cmd_t.
module f8vcw_ctrl import f8vcw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_opcode,
  input  dp_stat_t        stat,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            out_valid
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_opcode == OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = stat.walk_op ? S_WALK_INIT : S_DONE;
      end
      S_WALK_INIT: begin
        state_nxt = stat.start_out ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) state_nxt = stat.walk_ok ? S_MUL1 : S_DONE;
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_CLEAR:     cmd.clr_en    = 1'b1;
      S_SCAN:      cmd.scan_en   = 1'b1;
      S_WALK_INIT: cmd.walk_init = 1'b1;
      S_WALK:      cmd.walk_en   = 1'b1;
      S_MUL1:      cmd.mul1_en   = 1'b1;
      S_MUL2:      cmd.mul2_en   = 1'b1;
      S_DONE:      out_valid     = 1'b1;
      default:     busy          = 1'b1;
    endcase
  end

endmodule

FILE: hw/rtl/f8vcw_dp.sv
// f8vcw_dp: datapath of the vote and chain-walk unit: config registers,
// table memory, legality scan, chain walker and size multipliers. Uses f8vcw_pkg.
module f8vcw_dp import f8vcw_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int COPIES       = DEF_COPIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [BYTE_W-1:0]     in_entry_index,
  input  logic [BYTE_W-1:0]     in_copy_a,
  input  logic [BYTE_W-1:0]     in_copy_b,
  input  logic [BYTE_W-1:0]     in_copy_c,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [BYTE_W-1:0]     voted_value,
  output logic                  copies_disagree,
  output logic [CNT_W-1:0]      valid_length,
  output walk_stat_t            walk_status,
  output logic [CNT_W-1:0]      chain_length,
  output logic [CS_W-1:0]       last_used_sectors,
  output logic [SECS_W-1:0]     sector_count,
  output logic [BYTES_W-1:0]    byte_size
);

  localparam int               AW      = $clog2(MAX_CLUSTERS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLUSTERS);
  localparam logic [AW-1:0]    LAST_AD = AW'(MAX_CLUSTERS - 1);

  // configuration
  logic [CNT_W-1:0]  num_clusters_r;
  logic [CS_W-1:0]   cluster_sectors_r;
  logic [CPT_W-1:0]  clusters_per_track_r;
  logic [SB_W-1:0]   sector_bytes_r;
  logic [BYTE_W-1:0] free_code_r;
  logic [BYTE_W-1:0] reserved_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r       <= RST_NUM_CLUSTERS;
      cluster_sectors_r    <= RST_CLUSTER_SECS;
      clusters_per_track_r <= RST_CLUSTERS_TRK;
      sector_bytes_r       <= RST_SECTOR_BYTES;
      free_code_r          <= RST_FREE_CODE;
      reserved_code_r      <= RST_RESERVED_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS:       num_clusters_r       <= cfg_data[CNT_W-1:0];
        CFG_CLUSTER_SECTORS:    cluster_sectors_r    <= cfg_data[CS_W-1:0];
        CFG_CLUSTERS_PER_TRACK: clusters_per_track_r <= cfg_data[CPT_W-1:0];
        CFG_SECTOR_BYTES:       sector_bytes_r       <= cfg_data[SB_W-1:0];
        CFG_FREE_CODE:          free_code_r          <= cfg_data[BYTE_W-1:0];
        CFG_RESERVED_CODE:      reserved_code_r      <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // clusters in use, track size (zero acts as one)
  logic [CNT_W-1:0] n_used;
  logic [CPT_W-1:0] per_eff;
  assign n_used  = (num_clusters_r > MAX_CNT) ? MAX_CNT : num_clusters_r;
  assign per_eff = (clusters_per_track_r == '0) ? CPT_W'(1) : clusters_per_track_r;

  // item registers
  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] idx_r;
  logic              mismatch_r;
  vote_t             vt;
  logic              is_load, idx_in_range;

  assign vt           = vote3(COPIES, in_copy_a, in_copy_b, in_copy_c);
  assign is_load      = (in_opcode == OP_LOAD);
  assign idx_in_range = ({1'b0, in_entry_index} < MAX_CNT);

  // table memory, one write and one registered read port
  logic [BYTE_W-1:0] table_mem [MAX_CLUSTERS];
  logic [BYTE_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr, wr_addr, clr_cnt_r, cur_r;
  logic [BYTE_W-1:0] wr_data;
  logic              wr_en;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (cmd.clr_en) begin
      wr_en = 1'b1;
    end else if (cmd.accept && is_load && idx_in_range) begin
      wr_en   = 1'b1;
      wr_addr = in_entry_index[AW-1:0];
      wr_data = vt.value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    rd_data_r <= table_mem[rd_addr];
  end

  // classify the entry just read
  logic rd_is_ptr, rd_is_end, rd_legal;
  logic [BYTE_W-1:0] rd_off;
  assign rd_off    = rd_data_r - END_BASE;
  assign rd_is_ptr = ({1'b0, rd_data_r} < n_used);
  assign rd_is_end = (rd_data_r >= END_BASE) && (rd_off <= BYTE_W'(cluster_sectors_r));
  assign rd_legal  = rd_is_ptr || rd_is_end || (rd_data_r == free_code_r) ||
                     (rd_data_r == reserved_code_r);

  // legality scan: issue stage counts entries and track base, check stage follows it
  logic [CNT_W-1:0] scan_cnt_r, base_r, chk_base_r, vlen_r;
  logic [CPT_W-1:0] pos_r;
  logic             chk_v_r, issue_ok, scan_found, scan_done, track_wrap;

  assign issue_ok   = (scan_cnt_r < n_used);
  assign scan_found = chk_v_r && !rd_legal;
  assign scan_done  = scan_found || (!issue_ok && !chk_v_r);
  assign track_wrap = ({1'b0, pos_r} + (CPT_W + 1)'(1)) >= {1'b0, per_eff};

  // walk step
  logic              walk_done, walk_ok;
  walk_stat_t        walk_stat_nxt;
  logic [AW-1:0]     next_cur;
  logic [MAX_CLUSTERS-1:0] visited_r;
  logic [CNT_W-1:0]  cur_ext;

  assign cur_ext  = CNT_W'(cur_r);
  assign next_cur = rd_data_r[AW-1:0];

  always_comb begin
    walk_done     = 1'b1;
    walk_ok       = 1'b0;
    walk_stat_nxt = WS_OK;
    if (visited_r[cur_r]) begin
      walk_stat_nxt = WS_CYCLIC;
    end else if (cur_ext >= vlen_r) begin
      walk_stat_nxt = WS_ILLEGAL;
    end else if (rd_is_ptr) begin
      walk_done = 1'b0;
    end else if (rd_is_end) begin
      walk_ok = 1'b1;
    end else begin
      walk_stat_nxt = (rd_data_r == free_code_r) ? WS_FREE : WS_RESERVED;
    end
  end

  // read address select
  always_comb begin
    rd_addr = cur_r;
    if (cmd.scan_en) begin
      rd_addr = scan_cnt_r[AW-1:0];
    end else if (cmd.walk_init) begin
      rd_addr = idx_r[AW-1:0];
    end else if (cmd.walk_en) begin
      rd_addr = next_cur;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= '0;
      mismatch_r <= 1'b0;
      clr_cnt_r  <= '0;
      scan_cnt_r <= '0;
      base_r     <= '0;
      pos_r      <= '0;
      chk_v_r    <= 1'b0;
      visited_r  <= '0;
      cur_r      <= '0;
    end else begin
      if (cmd.accept) begin
        op_r <= in_opcode;
        if (in_opcode == OP_CLEAR) begin
          mismatch_r <= 1'b0;
        end else if (is_load && vt.disagree) begin
          mismatch_r <= 1'b1;
        end
      end
      // clear sweep
      clr_cnt_r <= cmd.clr_en ? clr_cnt_r + AW'(1) : '0;
      // scan issue stage
      if (cmd.scan_en) begin
        chk_v_r <= issue_ok;
        if (issue_ok) begin
          scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          if (track_wrap) begin
            pos_r  <= '0;
            base_r <= scan_cnt_r + CNT_W'(1);
          end else begin
            pos_r <= pos_r + CPT_W'(1);
          end
        end
      end else begin
        chk_v_r    <= 1'b0;
        scan_cnt_r <= '0;
        base_r     <= '0;
        pos_r      <= '0;
      end
      // walker
      if (cmd.walk_init) begin
        visited_r <= '0;
        cur_r     <= idx_r[AW-1:0];
      end else if (cmd.walk_en) begin
        if (!visited_r[cur_r]) visited_r[cur_r] <= 1'b1;
        if (!walk_done) cur_r <= next_cur;
      end
    end
  end

  // payload and results
  logic [BYTE_W-1:0]  voted_r;
  walk_stat_t         status_r;
  logic [CNT_W-1:0]   len_r;
  logic [CS_W-1:0]    last_r;
  logic [SECS_W-1:0]  secs_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [SECS_W:0]    mul1_prod;
  logic [SECS_W+SB_W-1:0] mul2_prod;

  assign mul1_prod = (SECS_W + 1)'(len_r - CNT_W'(1)) * (SECS_W + 1)'(cluster_sectors_r) +
                     (SECS_W + 1)'(last_r);
  assign mul2_prod = (SECS_W + SB_W)'(secs_r) * (SECS_W + SB_W)'(sector_bytes_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r    <= in_entry_index;
      voted_r  <= is_load ? vt.value : '0;
      status_r <= WS_OK;
      len_r    <= '0;
      last_r   <= '0;
      secs_r   <= '0;
      bytes_r  <= '0;
    end
    if (cmd.scan_en) begin
      chk_base_r <= base_r;
      if (scan_found) begin
        vlen_r <= chk_base_r;
      end else if (scan_done) begin
        vlen_r <= n_used;
      end
    end
    if (cmd.walk_init && !({1'b0, idx_r} < n_used)) begin
      status_r <= WS_START_OUT;
    end
    if (cmd.walk_en) begin
      status_r <= walk_stat_nxt;
      if (!visited_r[cur_r]) len_r <= len_r + CNT_W'(1);
      if (walk_ok) last_r <= rd_off[CS_W-1:0];
    end
    if (cmd.mul1_en) begin
      secs_r <= mul1_prod[SECS_W-1:0];
    end
    if (cmd.mul2_en) begin
      bytes_r <= (mul2_prod > (SECS_W + SB_W)'(BYTE_MAX)) ? BYTE_MAX
                                                          : mul2_prod[BYTES_W-1:0];
    end
  end

  // status to the controller
  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_cnt_r == LAST_AD);
    stat.scan_done = scan_done;
    stat.walk_op   = (op_r == OP_WALK);
    stat.start_out = !({1'b0, idx_r} < n_used);
    stat.walk_done = walk_done;
    stat.walk_ok   = walk_ok;
  end

  assign voted_value       = voted_r;
  assign copies_disagree   = mismatch_r;
  assign valid_length      = vlen_r;
  assign walk_status       = status_r;
  assign chain_length      = len_r;
  assign last_used_sectors = last_r;
  assign sector_count      = secs_r;
  assign byte_size         = bytes_r;

endmodule

FILE: hw/rtl/fat8_vote_and_chain_walk_unit.sv
// fat8_vote_and_chain_walk_unit: top level of the allocation-table vote and
// chain-walk unit. Depends on f8vcw_pkg, f8vcw_ctrl and f8vcw_dp.
//
// Usage:
//   Input: an item (opcode, entry index, three copies) is taken at a clock
//   edge with start high and busy low. Opcode clear starts a new table, load
//   votes the copies and stores the entry, walk follows a chain.
//   Result: one result per item, shown for exactly one cycle with out_valid
//   high; the receiver cannot stall, so results must be taken when shown.
//   Config: cfg_we writes register cfg_index with cfg_data; write only while
//   busy is low.
//   Sequence: every item rescans the table for illegal entries, one entry per
//   cycle through the single memory read port. Clear first zero-fills every
//   table entry. Walk then loads the start entry, steps through the chain one
//   visited cluster at a time and, for a chain that ends in an end code, forms
//   the sizes in the multiply states MUL1 and MUL2. One item is in flight at a time.
//   Reset: registers take their default values, the disagree flag clears;
//   table contents are undefined until loaded or cleared.
module fat8_vote_and_chain_walk_unit import f8vcw_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int COPIES       = DEF_COPIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [BYTE_W-1:0]     in_entry_index,
  input  logic [BYTE_W-1:0]     in_copy_a,
  input  logic [BYTE_W-1:0]     in_copy_b,
  input  logic [BYTE_W-1:0]     in_copy_c,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_voted_value,
  output logic                  out_copies_disagree,
  output logic [CNT_W-1:0]      out_valid_length,
  output logic [STAT_W-1:0]     out_walk_status,
  output logic [CNT_W-1:0]      out_chain_length,
  output logic [CS_W-1:0]       out_last_used_sectors,
  output logic [SECS_W-1:0]     out_sector_count,
  output logic [BYTES_W-1:0]    out_byte_size,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  walk_stat_t walk_status;

  f8vcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  f8vcw_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .COPIES       (COPIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_copy_a         (in_copy_a),
    .in_copy_b         (in_copy_b),
    .in_copy_c         (in_copy_c),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .voted_value       (out_voted_value),
    .copies_disagree   (out_copies_disagree),
    .valid_length      (out_valid_length),
    .walk_status       (walk_status),
    .chain_length      (out_chain_length),
    .last_used_sectors (out_last_used_sectors),
    .sector_count      (out_sector_count),
    .byte_size         (out_byte_size)
  );

  assign out_walk_status = walk_status;

  // an accepted item keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("unit not busy after accepting an item");

  // one result per item, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a failed walk reports no size
  a_err_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_walk_status != WS_OK |->
      out_sector_count == '0 && out_byte_size == '0 && out_last_used_sectors == '0)
    else $error("size reported on a failed walk");

  // a start outside the table visits nothing
  a_start_out_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_walk_status == WS_START_OUT |-> out_chain_length == '0)
    else $error("chain length nonzero for a start outside the table");

endmodule

FILE: dv/fat8_vote_and_chain_walk_unit_tb.sv
// fat8_vote_and_chain_walk_unit_tb: self-checking testbench for the allocation-table
// vote and chain-walk unit; predicts every result in its own table image.
// Depends on f8vcw_pkg and fat8_vote_and_chain_walk_unit.
module fat8_vote_and_chain_walk_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import f8vcw_pkg::*;

  localparam int MAX_CL         = 256;
  localparam int TOTAL_ITEMS    = 450;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       in_opcode;
  logic [BYTE_W-1:0]     in_entry_index;
  logic [BYTE_W-1:0]     in_copy_a;
  logic [BYTE_W-1:0]     in_copy_b;
  logic [BYTE_W-1:0]     in_copy_c;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_voted_value;
  logic                  out_copies_disagree;
  logic [CNT_W-1:0]      out_valid_length;
  logic [STAT_W-1:0]     out_walk_status;
  logic [CNT_W-1:0]      out_chain_length;
  logic [CS_W-1:0]       out_last_used_sectors;
  logic [SECS_W-1:0]     out_sector_count;
  logic [BYTES_W-1:0]    out_byte_size;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fat8_vote_and_chain_walk_unit dut (.*);

  // one result of the unit
  typedef struct {
    logic [BYTE_W-1:0]  voted;
    logic               disagree;
    logic [CNT_W-1:0]   valid_len;
    walk_stat_t         status;
    logic [CNT_W-1:0]   chain_len;
    logic [CS_W-1:0]    last_secs;
    logic [SECS_W-1:0]  sectors;
    logic [BYTES_W-1:0] bytes;
  } unit_result_t;

  unit_result_t pending_results[$];
  unit_result_t want;

  // predicted table image, sticky flag and register copies
  logic [BYTE_W-1:0] fat_image [MAX_CL];
  logic              disagree_flag;
  int unsigned       m_num_clusters, m_cluster_secs, m_per_track;
  int unsigned       m_sector_bytes, m_free, m_reserved;

  int sender_idle_pct;
  int items_sent;
  int mismatch_count;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clusters_in_use();
    return (m_num_clusters > MAX_CL) ? MAX_CL : m_num_clusters;
  endfunction

  function automatic bit is_end_code(int unsigned v);
    return v >= END_BASE && (v - END_BASE) <= m_cluster_secs;
  endfunction

  function automatic bit is_legal_code(int unsigned v);
    return v < clusters_in_use() || is_end_code(v) || v == m_free || v == m_reserved;
  endfunction

  // lowest illegal entry below the clusters in use, rounded down to a track
  function automatic int unsigned table_valid_len();
    int unsigned n, per;
    n   = clusters_in_use();
    per = (m_per_track == 0) ? 1 : m_per_track;
    for (int unsigned i = 0; i < n; i++)
      if (!is_legal_code(fat_image[i])) return i - (i % per);
    return n;
  endfunction

  // majority of three copies, smallest value when all differ
  function automatic logic [BYTE_W-1:0] majority3(logic [BYTE_W-1:0] a, b, c);
    logic [BYTE_W-1:0] low;
    if (a == b || a == c) return a;
    if (b == c) return b;
    low = (a < b) ? a : b;
    return (c < low) ? c : low;
  endfunction

  // value that no rule accepts under the current settings, if one is found
  function automatic logic [BYTE_W-1:0] illegal_code();
    logic [BYTE_W-1:0] v;
    v = '0;
    for (int t = 0; t < 32; t++) begin
      v = $urandom_range(255);
      if (!is_legal_code(v)) return v;
    end
    return v;
  endfunction

  // applies one item to the predicted state and returns its result
  function automatic unit_result_t predict_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] idx,
                                                logic [BYTE_W-1:0] a, b, c);
    unit_result_t    r;
    bit [MAX_CL-1:0] seen;
    int unsigned     n, vl, cur, v, len, last_sec, secs;
    bit              done;
    longint unsigned prod;
    r.voted = '0; r.status = WS_OK; r.chain_len = '0;
    r.last_secs = '0; r.sectors = '0; r.bytes = '0;
    if (op == OP_CLEAR) begin
      foreach (fat_image[i]) fat_image[i] = '0;
      disagree_flag = 1'b0;
    end else if (op == OP_LOAD) begin
      r.voted = majority3(a, b, c);
      if (!(a == b && b == c)) disagree_flag = 1'b1;
      fat_image[idx] = r.voted;
    end
    n  = clusters_in_use();
    vl = table_valid_len();
    // chain walk with visited map
    if (op == OP_WALK) begin
      if (idx >= n) begin
        r.status = WS_START_OUT;
      end else begin
        seen = '0; cur = idx; len = 0; last_sec = 0; done = 1'b0;
        for (int unsigned steps = 0; steps <= n && !done; steps++) begin
          if (seen[cur]) begin
            r.status = WS_CYCLIC;
            done = 1'b1;
          end else begin
            seen[cur] = 1'b1;
            len++;
            v = fat_image[cur];
            if (cur >= vl) begin
              r.status = WS_ILLEGAL;
              done = 1'b1;
            end else if (v < n) begin
              cur = v;
            end else if (is_end_code(v)) begin
              last_sec = v - END_BASE;
              done = 1'b1;
            end else begin
              r.status = (v == m_free) ? WS_FREE : WS_RESERVED;
              done = 1'b1;
            end
          end
        end
        r.chain_len = len;
        if (r.status == WS_OK) begin
          secs = (len - 1) * m_cluster_secs + last_sec;
          prod = longint'(secs) * m_sector_bytes;
          r.last_secs = last_sec;
          r.sectors   = secs;
          r.bytes     = (prod > BYTE_MAX) ? BYTE_MAX : prod[BYTES_W-1:0];
        end
      end
    end
    r.disagree  = disagree_flag;
    r.valid_len = vl;
    return r;
  endfunction

  // drive one item, wait for the unit to take it, record what it should return
  task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] idx,
                           logic [BYTE_W-1:0] a, b, c);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_copy_a      <= a;
    in_copy_b      <= b;
    in_copy_c      <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_item(op, idx, a, b, c));
    items_sent++;
  endtask

  // load with one copy sometimes damaged; the majority still holds value
  task automatic load_entry(logic [BYTE_W-1:0] idx, logic [BYTE_W-1:0] value);
    logic [BYTE_W-1:0] cp [3];
    cp = '{value, value, value};
    if ($urandom_range(99) < 20) cp[$urandom_range(2)] = value ^ 8'($urandom_range(1, 255));
    send_item(OP_LOAD, idx, cp[0], cp[1], cp[2]);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_NUM_CLUSTERS:       m_num_clusters = value & 32'h1FF;
      CFG_CLUSTER_SECTORS:    m_cluster_secs = value & 32'h1F;
      CFG_CLUSTERS_PER_TRACK: m_per_track    = value & 32'h7F;
      CFG_SECTOR_BYTES:       m_sector_bytes = value & 32'h7FF;
      CFG_FREE_CODE:          m_free         = value & 32'hFF;
      CFG_RESERVED_CODE:      m_reserved     = value & 32'hFF;
      default: ;
    endcase
  endtask

  // all six registers, written only with nothing in flight
  task automatic apply_config(int unsigned nc, cs, cpt, sb, fc, rc);
    wait_idle();
    write_reg(CFG_NUM_CLUSTERS, nc);
    write_reg(CFG_CLUSTER_SECTORS, cs);
    write_reg(CFG_CLUSTERS_PER_TRACK, cpt);
    write_reg(CFG_SECTOR_BYTES, sb);
    write_reg(CFG_FREE_CODE, fc);
    write_reg(CFG_RESERVED_CODE, rc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reset settings: votes, every walk outcome, entry above the table, opcode 3
  task automatic test_default_config();
    sender_idle_pct = 26;
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd0, 8'd1, 8'd1, 8'd1);
    send_item(OP_LOAD, 8'd1, 8'd2, 8'd2, 8'd9);
    send_item(OP_LOAD, 8'd2, 8'hC3, 8'hC3, 8'hC3);
    send_item(OP_WALK, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd3, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_WALK, 8'd3, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_LOAD, 8'd4, 8'hFE, 8'hFE, 8'hFE);
    send_item(OP_WALK, 8'd4, 8'h00, 8'h00, 8'h00);
    // 5 -> 7 -> 5 loop, first load has all copies different
    send_item(OP_LOAD, 8'd5, 8'd7, 8'd9, 8'd8);
    send_item(OP_LOAD, 8'd7, 8'd5, 8'd0, 8'd5);
    send_item(OP_WALK, 8'd5, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd255, 8'd0, 8'd128, 8'd255);
    // end code past cluster_sectors is illegal and cuts the table to one track
    send_item(OP_LOAD, 8'd6, 8'hC5, 8'hC5, 8'hC5);
    send_item(OP_WALK, 8'd5, 8'h00, 8'h00, 8'h00);
    send_item(OP_WALK, 8'd200, 8'h00, 8'h00, 8'h00);
    send_item(OP_UNUSED, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_item(OP_CLEAR, 8'hAA, 8'h55, 8'hAA, 8'h55);
  endtask

  // track rounding with zero and 64-cluster track, one-cluster table, end before free
  task automatic test_track_rounding();
    sender_idle_pct = 74;
    apply_config(40, 1, 0, 128, 40, 41);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd13, 8'h90, 8'h90, 8'h90);
    send_item(OP_WALK, 8'd12, 8'h00, 8'h00, 8'h00);
    send_item(OP_WALK, 8'd13, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd14, 8'd40, 8'd40, 8'd40);
    apply_config(40, 1, 64, 128, 40, 41);
    send_item(OP_WALK, 8'd0, 8'h00, 8'h00, 8'h00);
    apply_config(1, 1, 7, 1024, 8'hC1, 8'hC0);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'd0, 8'hC1, 8'hC1, 8'hC1);
    send_item(OP_WALK, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_WALK, 8'd1, 8'h00, 8'h00, 8'h00);
  endtask

  // longest chains: 192 clusters to an end code, then all 256 in one loop
  task automatic test_long_chain();
    sender_idle_pct = 0;
    apply_config(192, 16, 4, 1024, 8'hFF, 8'hFE);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 191; i++) load_entry(i, i + 1);
    load_entry(8'd191, 8'hD0);
    send_item(OP_WALK, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_WALK, 8'd100, 8'h00, 8'h00, 8'h00);
    // num_clusters above the table size saturates at 256
    apply_config(511, 16, 0, 1024, 8'hFF, 8'hFE);
    for (int i = 191; i < 255; i++) load_entry(i, i + 1);
    load_entry(8'd255, 8'd0);
    send_item(OP_WALK, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_WALK, 8'd128, 8'h00, 8'h00, 8'h00);
  endtask

  // random settings, random chains with random ends, noise and walks
  task automatic test_random_chains();
    int unsigned       nc, cs, cpt, sb, fc, rc, n, len, cur;
    int                round;
    bit [MAX_CL-1:0]   taken;
    int unsigned       used_cnt;
    logic [BYTE_W-1:0] members[$];
    logic [BYTE_W-1:0] heads[$];
    logic [BYTE_W-1:0] term, start_idx;
    round = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (round % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 74;
        default: sender_idle_pct = 26;
      endcase
      case ($urandom_range(9))
        0:       nc = $urandom_range(1, 4);
        1:       nc = 256;
        default: nc = $urandom_range(6, 48);
      endcase
      cs = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 1 : 16) : $urandom_range(1, 16);
      case ($urandom_range(5))
        0:       cpt = 0;
        1:       cpt = 64;
        default: cpt = $urandom_range(1, 8);
      endcase
      case ($urandom_range(3))
        0:       sb = 128;
        1:       sb = 1024;
        default: sb = $urandom_range(128, 1024);
      endcase
      fc = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(END_BASE + cs + 1, 255);
      rc = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(END_BASE + cs + 1, 255);
      apply_config(nc, cs, cpt, sb, fc, rc);
      n = clusters_in_use();
      send_item(OP_CLEAR, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(255));
      taken = '0;
      used_cnt = 0;
      heads.delete();
      // build a few chains on distinct clusters
      repeat ($urandom_range(1, 3)) begin
        members.delete();
        len = $urandom_range(1, (n < 10) ? n : 10);
        while (members.size() < len && used_cnt < n) begin
          do cur = $urandom_range(n - 1); while (taken[cur]);
          taken[cur] = 1'b1;
          used_cnt++;
          members.push_back(cur);
        end
        if (members.size() == 0) break;
        for (int k = 0; k + 1 < members.size(); k++) load_entry(members[k], members[k + 1]);
        case ($urandom_range(9))
          0:       term = m_free;
          1:       term = m_reserved;
          2:       term = illegal_code();
          3:       term = members[$urandom_range(members.size() - 1)];
          default: term = END_BASE + $urandom_range(cs);
        endcase
        load_entry(members[members.size() - 1], term);
        heads.push_back(members[0]);
        // occasional noise between chains
        case ($urandom_range(7))
          0: send_item(OP_LOAD, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
          1: send_item(OP_UNUSED, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
          default: ;
        endcase
      end
      // walks mostly from chain heads
      repeat ($urandom_range(2, 5)) begin
        if (heads.size() != 0 && $urandom_range(4) != 0)
          start_idx = heads[$urandom_range(heads.size() - 1)];
        else
          start_idx = $urandom_range(255);
        send_item(OP_WALK, start_idx, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255));
      end
      round++;
    end
  endtask

  task automatic check_field(string name, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no item pending, actual voted %0d status %0d",
                 $time, out_voted_value, out_walk_status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("voted_value", want.voted, out_voted_value);
        check_field("copies_disagree", want.disagree, out_copies_disagree);
        check_field("valid_length", want.valid_len, out_valid_length);
        check_field("walk_status", int'(want.status), out_walk_status);
        check_field("chain_length", want.chain_len, out_chain_length);
        check_field("last_used_sectors", want.last_secs, out_last_used_sectors);
        check_field("sector_count", want.sectors, out_sector_count);
        check_field("byte_size", want.bytes, out_byte_size);
      end
    end
  end

  // watchdog: no item taken and no result for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("fat8_vote_and_chain_walk_unit test failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_opcode      = OP_CLEAR;
    in_entry_index = '0;
    in_copy_a      = '0;
    in_copy_b      = '0;
    in_copy_c      = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_NUM_CLUSTERS;
    cfg_data       = '0;
    m_num_clusters = RST_NUM_CLUSTERS;
    m_cluster_secs = RST_CLUSTER_SECS;
    m_per_track    = RST_CLUSTERS_TRK;
    m_sector_bytes = RST_SECTOR_BYTES;
    m_free         = RST_FREE_CODE;
    m_reserved     = RST_RESERVED_CODE;
    disagree_flag  = 1'b0;
    foreach (fat_image[i]) fat_image[i] = '0;
    sender_idle_pct = 0;
    items_sent      = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_track_rounding();
    test_long_chain();
    test_random_chains();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("fat8_vote_and_chain_walk_unit test passed");
    else
      $display("fat8_vote_and_chain_walk_unit test failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/f8vcw_pkg.sv
hw/rtl/f8vcw_ctrl.sv
hw/rtl/f8vcw_dp.sv
hw/rtl/fat8_vote_and_chain_walk_unit.sv
dv/fat8_vote_and_chain_walk_unit_tb.sv
